### design/tlb_page_table_translation_top_macros.svh
// assertion macros for the address translation block
// used by files that check their own logic; expects clk_i and rst_ni in scope
`ifndef TLB_PAGE_TABLE_TRANSLATION_TOP_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATION_TOP_MACROS_SVH

`ifndef SYNTHESIS

// concurrent property checked on every clock edge outside reset
`define TLBPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define TLBPT_ASSERT_NEVER(lbl, cond, msg) \
  `TLBPT_ASSERT(lbl, !(cond), msg)

`else

`define TLBPT_ASSERT(lbl, prop, msg)
`define TLBPT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### design/tlbpt_pkg.sv
// shared types and constants of the address translation block
// no dependencies
package tlbpt_pkg;

  localparam int unsigned VA_W         = 20;
  localparam int unsigned PA_W         = 20;
  localparam int unsigned FRAME_W      = 11;
  localparam int unsigned OFFSET_BITS  = 9;
  localparam int unsigned TLB_ENTRIES  = 16;
  localparam int unsigned PAGE_ENTRIES = 512;
  localparam int unsigned VPN_W        = $clog2(PAGE_ENTRIES);
  localparam int unsigned SLOT_W       = $clog2(TLB_ENTRIES);
  localparam int unsigned TAG_W        = VPN_W - SLOT_W;
  // first address bit that must be zero for a legal address
  localparam int unsigned LIMIT_BIT    = OFFSET_BITS + VPN_W;

  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 24;
  localparam int unsigned SRC_W        = 2;

  typedef enum logic [SRC_W-1:0] {
    SRC_ILLEGAL = 2'd0,
    SRC_TLB     = 2'd1,
    SRC_TABLE   = 2'd2,
    SRC_FAULT   = 2'd3
  } src_e;

  // one page table entry
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  // access request to the page table
  typedef struct packed {
    logic             rd_en;
    logic [VPN_W-1:0] rd_addr;
    logic             wr_en;
    logic [VPN_W-1:0] wr_addr;
    pte_t             wr_pte;
  } ptab_req_t;

endpackage

### design/tlbpt_ptab.sv
// page table memory with registered read and a clearing sweep after reset
// depends on tlbpt_pkg
module tlbpt_ptab (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::ptab_req_t req_i,
  output tlbpt_pkg::pte_t     rd_pte_o,
  output logic                busy_o
);

  tlbpt_pkg::pte_t                  mem_q [tlbpt_pkg::PAGE_ENTRIES];
  tlbpt_pkg::pte_t                  rd_pte_q;
  logic                             clr_busy_q;
  logic [tlbpt_pkg::VPN_W-1:0]      clr_addr_q;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == tlbpt_pkg::VPN_W'(tlbpt_pkg::PAGE_ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // single write port, sweep has priority
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_pte;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_pte_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_pte_o = rd_pte_q;
  assign busy_o   = clr_busy_q;

endmodule

### design/tlb_page_table_translation_top.sv
// Translates 18-bit virtual addresses through a direct-mapped 16-entry TLB
// backed by a 512-entry page table, installing the supplied frame on a page
// fault. An accepted item first reads the page table memory (registered read);
// the working stage then resolves TLB hit, table hit or fault, writes back the
// TLB and page table and loads the result register, holding while the result
// register is full and not taken. The next item is taken once the previous one
// has left the working stage. After reset the page table is cleared one entry
// per cycle, during which s_axis_tready stays low. Addresses at or above 2^18
// give source 0 and address 0 and change neither the TLB nor the page table.
// depends on tlbpt_pkg, tlbpt_ptab and the assertion macro header
`include "tlb_page_table_translation_top_macros.svh"

module tlb_page_table_translation_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [19:0] vaddr, [30:20] fault_frame, [31] zero
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] paddr, [23:20] zero
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] source
  output logic [tlbpt_pkg::SRC_W-1:0]       m_axis_tuser
);

  // input fields
  logic [tlbpt_pkg::VA_W-1:0]    in_va;
  logic [tlbpt_pkg::FRAME_W-1:0] in_ff;
  logic                          in_acc;
  logic                          busy;

  // working stage
  logic                          s1_valid_q;
  logic [tlbpt_pkg::VA_W-1:0]    s1_va_q;
  logic [tlbpt_pkg::FRAME_W-1:0] s1_ff_q;
  logic                          fire;

  // tlb storage
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_q;
  logic [tlbpt_pkg::TAG_W-1:0]       tlb_tag_q   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0]     tlb_frame_q [tlbpt_pkg::TLB_ENTRIES];

  // decode and resolve
  logic                              illegal;
  logic [tlbpt_pkg::VPN_W-1:0]       vpn;
  logic [tlbpt_pkg::SLOT_W-1:0]      slot;
  logic [tlbpt_pkg::TAG_W-1:0]       tag;
  logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;
  logic                              tlb_hit;
  tlbpt_pkg::pte_t                   rd_pte;
  logic [tlbpt_pkg::FRAME_W-1:0]     frame;
  tlbpt_pkg::src_e                   src;
  logic                              tlb_wr;
  tlbpt_pkg::ptab_req_t              ptab_req;

  // result register
  logic                              out_valid_q;
  logic [tlbpt_pkg::PA_W-1:0]        out_pa_q;
  tlbpt_pkg::src_e                   out_src_q;
  logic [tlbpt_pkg::PA_W-1:0]        out_pa_d;

  assign in_va  = s_axis_tdata[tlbpt_pkg::VA_W-1:0];
  assign in_ff  = s_axis_tdata[tlbpt_pkg::VA_W +: tlbpt_pkg::FRAME_W];

  // one item in the working stage at a time
  assign s_axis_tready = !s1_valid_q && !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_va_q <= in_va;
      s1_ff_q <= in_ff;
    end
  end

  // address split of the held item
  assign illegal = |s1_va_q[tlbpt_pkg::VA_W-1:tlbpt_pkg::LIMIT_BIT];
  assign vpn     = s1_va_q[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::VPN_W];
  assign slot    = vpn[tlbpt_pkg::SLOT_W-1:0];
  assign tag     = vpn[tlbpt_pkg::VPN_W-1:tlbpt_pkg::SLOT_W];
  assign offset  = s1_va_q[tlbpt_pkg::OFFSET_BITS-1:0];
  assign tlb_hit = tlb_valid_q[slot] && (tlb_tag_q[slot] == tag);

  // pick the frame source
  always_comb begin
    priority if (illegal) begin
      frame = '0;
      src   = tlbpt_pkg::SRC_ILLEGAL;
    end else if (tlb_hit) begin
      frame = tlb_frame_q[slot];
      src   = tlbpt_pkg::SRC_TLB;
    end else if (rd_pte.valid) begin
      frame = rd_pte.frame;
      src   = tlbpt_pkg::SRC_TABLE;
    end else begin
      frame = s1_ff_q;
      src   = tlbpt_pkg::SRC_FAULT;
    end
  end

  assign out_pa_d = illegal ? '0 : tlbpt_pkg::PA_W'({frame, offset});
  assign tlb_wr   = fire && !illegal && !tlb_hit;

  // page table read on accept, write back on fault
  always_comb begin
    ptab_req.rd_en        = in_acc;
    ptab_req.rd_addr      = in_va[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::VPN_W];
    ptab_req.wr_en        = tlb_wr && (src == tlbpt_pkg::SRC_FAULT);
    ptab_req.wr_addr      = vpn;
    ptab_req.wr_pte.valid = 1'b1;
    ptab_req.wr_pte.frame = s1_ff_q;
  end

  tlbpt_ptab u_ptab (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ptab_req),
    .rd_pte_o (rd_pte),
    .busy_o   (busy)
  );

  // tlb refill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
    end else if (tlb_wr) begin
      tlb_valid_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tlb_wr) begin
      tlb_tag_q[slot]   <= tag;
      tlb_frame_q[slot] <= frame;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pa_q  <= out_pa_d;
      out_src_q <= src;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tlbpt_pkg::OUT_TDATA_W'(out_pa_q);
  assign m_axis_tuser  = out_src_q;

  // checks
  `TLBPT_ASSERT_NEVER(a_acc_busy, in_acc && (s1_valid_q || busy), "item taken while stage busy")
  `TLBPT_ASSERT(a_fire_out, fire |=> out_valid_q, "finished item did not reach output")
  `TLBPT_ASSERT(a_acc_done, in_acc |=> s1_valid_q, "accepted item lost")
  `TLBPT_ASSERT(a_fault_miss, ptab_req.wr_en |-> (fire && !tlb_hit && !rd_pte.valid && !illegal),
                "page table written outside a fault")

endmodule

### test/tlb_page_table_translation_checker.sv
// checker for the address translation block: watches both stream channels,
// predicts each translation and compares it with the block's result
// depends on tlbpt_pkg
module tlb_page_table_translation_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // [19:0] vaddr, [30:20] fault_frame, [31] zero
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [19:0] paddr, [23:20] zero
  input  logic [tlbpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] source
  input  logic [tlbpt_pkg::SRC_W-1:0]         m_axis_tuser,
  output int unsigned                         error_count_o,
  output int unsigned                         outstanding_o,
  output logic [3:0][31:0]                    source_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [tlbpt_pkg::PA_W-1:0] phys;
    tlbpt_pkg::src_e            source;
  } translation_t;

  // shadow copy of the TLB and page table
  logic                          tlb_valid_q  [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TAG_W-1:0]   tlb_tag_q    [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0] tlb_frame_q  [tlbpt_pkg::TLB_ENTRIES];
  logic                          page_valid_q [tlbpt_pkg::PAGE_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0] page_frame_q [tlbpt_pkg::PAGE_ENTRIES];

  translation_t expected_translations[$];
  translation_t oldest;
  translation_t seen;

  // translate one address and update the shadow tables as the block would
  function automatic translation_t translate_address(
    logic [tlbpt_pkg::VA_W-1:0]    va,
    logic [tlbpt_pkg::FRAME_W-1:0] fault_frame
  );
    translation_t                       r;
    logic [tlbpt_pkg::VPN_W-1:0]        vpn;
    logic [tlbpt_pkg::SLOT_W-1:0]       slot;
    logic [tlbpt_pkg::TAG_W-1:0]        tag;
    logic [tlbpt_pkg::FRAME_W-1:0]      frame;
    logic [tlbpt_pkg::OFFSET_BITS-1:0]  offset;
    offset = va[tlbpt_pkg::OFFSET_BITS-1:0];
    vpn    = va[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::VPN_W];
    slot   = vpn[tlbpt_pkg::SLOT_W-1:0];
    tag    = vpn[tlbpt_pkg::VPN_W-1:tlbpt_pkg::SLOT_W];
    // anything with a bit set at or above the limit is illegal
    if (va[tlbpt_pkg::VA_W-1:tlbpt_pkg::LIMIT_BIT] != '0) begin
      r.phys   = '0;
      r.source = tlbpt_pkg::SRC_ILLEGAL;
      return r;
    end
    if (tlb_valid_q[slot] && tlb_tag_q[slot] == tag) begin
      frame    = tlb_frame_q[slot];
      r.source = tlbpt_pkg::SRC_TLB;
    end else begin
      if (page_valid_q[vpn]) begin
        frame    = page_frame_q[vpn];
        r.source = tlbpt_pkg::SRC_TABLE;
      end else begin
        // page fault installs the supplied frame
        frame             = fault_frame;
        page_frame_q[vpn] = frame;
        page_valid_q[vpn] = 1'b1;
        r.source          = tlbpt_pkg::SRC_FAULT;
      end
      tlb_valid_q[slot] = 1'b1;
      tlb_tag_q[slot]   = tag;
      tlb_frame_q[slot] = frame;
    end
    r.phys = tlbpt_pkg::PA_W'({frame, offset});
    return r;
  endfunction

  // compare results first, then predict the item taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
        tlb_valid_q[i] = 1'b0;
        tlb_tag_q[i]   = '0;
        tlb_frame_q[i] = '0;
      end
      for (int i = 0; i < tlbpt_pkg::PAGE_ENTRIES; i++) begin
        page_valid_q[i] = 1'b0;
        page_frame_q[i] = '0;
      end
      expected_translations.delete();
      error_count_o  = 0;
      outstanding_o  = 0;
      source_count_o = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.phys   = m_axis_tdata[tlbpt_pkg::PA_W-1:0];
        seen.source = tlbpt_pkg::src_e'(m_axis_tuser);
        if (expected_translations.size() == 0) begin
          $display("%0t: unexpected result paddr %05h source %s", $time,
                   seen.phys, seen.source.name());
          error_count_o++;
        end else begin
          oldest = expected_translations.pop_front();
          if (seen.phys !== oldest.phys) begin
            $display("%0t: paddr expected %05h actual %05h", $time,
                     oldest.phys, seen.phys);
            error_count_o++;
          end
          if (seen.source !== oldest.source) begin
            $display("%0t: source expected %0d actual %0d", $time,
                     oldest.source, m_axis_tuser);
            error_count_o++;
          end
          source_count_o[oldest.source] = source_count_o[oldest.source] + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_translations.push_back(
          translate_address(s_axis_tdata[tlbpt_pkg::VA_W-1:0],
                            s_axis_tdata[tlbpt_pkg::VA_W +: tlbpt_pkg::FRAME_W]));
      end
      outstanding_o = expected_translations.size();
    end
  end

endmodule

### test/tb_tlb_page_table_translation_top.sv
// testbench top for the address translation block: clock, reset, address
// stimulus with random idling on both sides, watchdog and verdict
// depends on tlbpt_pkg, the block and tlb_page_table_translation_checker
module tb_tlb_page_table_translation_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned STEADY_ITEMS   = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned HOT_PAGES      = 32;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [tlbpt_pkg::VA_W-1:0] VA_LIMIT =
    tlbpt_pkg::VA_W'(1) << tlbpt_pkg::LIMIT_BIT;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [tlbpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [tlbpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [tlbpt_pkg::SRC_W-1:0]       m_axis_tuser;

  int unsigned      error_count;
  int unsigned      outstanding;
  logic [3:0][31:0] source_count;

  logic        steady_tail     = 1'b0;
  logic        long_hold_done  = 1'b0;
  int unsigned results_seen    = 0;
  int unsigned stalled_cycles  = 0;
  int unsigned items_sent      = 0;

  logic [tlbpt_pkg::VPN_W-1:0] hot_vpn [HOT_PAGES];

  always #1 clk_i = ~clk_i;

  tlb_page_table_translation_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tlb_page_table_translation_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .error_count_o  (error_count),
    .outstanding_o  (outstanding),
    .source_count_o (source_count)
  );

  // offer one item, with an optional idle burst first, and wait for it to be taken
  task automatic send_item(input logic [tlbpt_pkg::VA_W-1:0] va,
                           input logic [tlbpt_pkg::FRAME_W-1:0] ff);
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ff, va};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // receiver: random stall bursts, one long hold-off, none in the tail
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done <= 1'b1;
        m_axis_tready  <= 1'b1;
      end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    logic [tlbpt_pkg::VPN_W-1:0]       vpn;
    logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;
    int unsigned                       pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first touch, offset extremes, illegal range, slot eviction
    send_item(tlbpt_pkg::VA_W'(0), tlbpt_pkg::FRAME_W'(0));     // fault with frame zero
    send_item(tlbpt_pkg::VA_W'(9'h1ff), '1);                   // tlb hit, fault frame ignored
    send_item(VA_LIMIT - 1, '1);                   // top legal page faults, frame all ones
    send_item(VA_LIMIT, '1);                       // first illegal address
    send_item('1, '1);                             // largest illegal address
    // illegal, upper bit only
    send_item(tlbpt_pkg::VA_W'(20'h80000), tlbpt_pkg::FRAME_W'(11'h2aa));
    // fault, offset zero
    send_item(VA_LIMIT - tlbpt_pkg::VA_W'(1 << tlbpt_pkg::OFFSET_BITS),
              tlbpt_pkg::FRAME_W'(5));
    // same slot, new tag
    send_item(tlbpt_pkg::VA_W'(15 << tlbpt_pkg::OFFSET_BITS),
              tlbpt_pkg::FRAME_W'(11'h555));
    send_item(VA_LIMIT - 1, tlbpt_pkg::FRAME_W'(0));            // evicted: page table hit
    // table hit
    send_item(tlbpt_pkg::VA_W'((15 << tlbpt_pkg::OFFSET_BITS) | 9'h0aa),
              tlbpt_pkg::FRAME_W'(11'h2aa));
    // slot 0 aliased
    send_item(tlbpt_pkg::VA_W'(16 << tlbpt_pkg::OFFSET_BITS),
              tlbpt_pkg::FRAME_W'(11'h2aa));
    send_item(tlbpt_pkg::VA_W'(9'h155), '1);                    // table hit on page zero
    send_item(tlbpt_pkg::VA_W'(9'h155), tlbpt_pkg::FRAME_W'(0)); // tlb hit again
    // fault, msb of frame
    send_item(tlbpt_pkg::VA_W'(20'h20000), tlbpt_pkg::FRAME_W'(11'h400));
    send_item(tlbpt_pkg::VA_W'(20'h20000 | 9'h100), tlbpt_pkg::FRAME_W'(0));
    // illegal with offset set
    send_item(VA_LIMIT | tlbpt_pkg::VA_W'(9'h1ff), tlbpt_pkg::FRAME_W'(1));
    // illegal, just above limit
    send_item(tlbpt_pkg::VA_W'(20'h40200), tlbpt_pkg::FRAME_W'(7));

    // random: mostly a hot set of pages, some spread, illegal and raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) begin
        foreach (hot_vpn[k]) begin
          hot_vpn[k] = tlbpt_pkg::VPN_W'($urandom_range(0, tlbpt_pkg::PAGE_ENTRIES - 1));
        end
      end
      if (i == RANDOM_ITEMS - STEADY_ITEMS) steady_tail <= 1'b1;
      offset = tlbpt_pkg::OFFSET_BITS'($urandom());
      pick   = $urandom_range(0, 9);
      if (pick < 7) begin
        vpn = hot_vpn[$urandom_range(0, HOT_PAGES - 1)];
        send_item(tlbpt_pkg::VA_W'({vpn, offset}), tlbpt_pkg::FRAME_W'($urandom()));
      end else if (pick == 7) begin
        vpn = tlbpt_pkg::VPN_W'($urandom());
        send_item(tlbpt_pkg::VA_W'({vpn, offset}), tlbpt_pkg::FRAME_W'($urandom()));
      end else if (pick == 8) begin
        send_item(tlbpt_pkg::VA_W'($urandom_range(VA_LIMIT, (1 << tlbpt_pkg::VA_W) - 1)),
                  tlbpt_pkg::FRAME_W'($urandom()));
      end else begin
        send_item(tlbpt_pkg::VA_W'($urandom()), tlbpt_pkg::FRAME_W'($urandom()));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching for anything stray
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items: %0d illegal, %0d tlb hits, %0d table hits, %0d faults",
             items_sent, source_count[tlbpt_pkg::SRC_ILLEGAL],
             source_count[tlbpt_pkg::SRC_TLB], source_count[tlbpt_pkg::SRC_TABLE],
             source_count[tlbpt_pkg::SRC_FAULT]);
    $display("random idling on both sides plus one %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (error_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/tlbpt_pkg.sv
design/tlbpt_ptab.sv
design/tlb_page_table_translation_top.sv
test/tlb_page_table_translation_checker.sv
test/tb_tlb_page_table_translation_top.sv
